FILE: sv/kcmpd_pkg.sv
package kcmpd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int VAL_W      = 32;
    localparam int RUN_W      = 39;
    localparam int SUM_W      = 48;
    localparam int POS_W      = 6;
    localparam int K_W        = 7;
    localparam int ADDR_W     = 3;
    localparam logic [K_W-1:0] K_RESET = K_W'(2);
    localparam logic [K_W-1:0] K_MIN   = K_W'(2);
    localparam logic [ADDR_W-1:0] REG_WINDOW_SIZE = ADDR_W'(0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEEK,
        ST_EMIT,
        ST_TOOFEW
    } t_state;

    typedef enum logic [2:0] {
        PH_READ,
        PH_MUL,
        PH_SUB,
        PH_ADD,
        PH_ACC,
        PH_CMP
    } t_phase;

    typedef struct packed {
        logic   insert;
        logic   scan_init;
        logic   phase_en;
        t_phase phase;
        logic   seek_rot;
        logic   seek_done;
        logic   emit_load;
        logic   toofew_load;
        logic   clear;
    } t_cmd;

    typedef struct packed {
        logic enough;
        logic elem_last;
        logic at_start;
        logic sel_last;
        logic slot_free;
    } t_stat;

endpackage

FILE: sv/k_cluster_min_pairwise_distance.sv
// k-point cluster selector.
// Points arrive on the input channel (i_valid/o_ready), one signed coordinate
// per beat, with i_last_item set on the final point of a set. Each point is
// inserted into a sorted chain of 64 cells as it is taken, so loading runs at one
// beat per cycle. Points past the 64th are dropped, but their last mark still
// closes the set.
// After the last beat the input stalls while the window scan runs: the sorted
// values rotate out of the chain one per element, each passing through read,
// multiply, subtract, add, accumulate and compare, and then the chain rotates
// on to the start of the best window found by the scan.
// The result channel (o_valid/i_ready) then carries k beats with the arrival
// positions of the best window in sorted order, the final one marked by
// o_last_result. If fewer than k points were loaded, a single beat with
// o_too_few and o_last_result set is sent instead. A stalled receiver simply
// holds the output register; a new set can be loaded while the final result
// still waits. Reset clears the set, the controller and the output valid flag,
// and sets window_size to 2. window_size is written over the APB port at
// address 0; values below 2 act as 2.
module k_cluster_min_pairwise_distance (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kcmpd_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [kcmpd_pkg::VAL_W-1:0]    i_coordinate,
    input  logic                                  i_last_item,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [kcmpd_pkg::POS_W-1:0]           o_position,
    output logic                                  o_last_result,
    output logic                                  o_too_few
);

    logic [kcmpd_pkg::K_W-1:0] r_window_size;
    logic [kcmpd_pkg::K_W-1:0] k_eff;
    kcmpd_pkg::t_cmd           cmd;
    kcmpd_pkg::t_stat          stat;

    // Configuration register. Writes land on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= kcmpd_pkg::K_RESET;
        end else if (psel && penable && pwrite && paddr == kcmpd_pkg::REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[kcmpd_pkg::K_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == kcmpd_pkg::REG_WINDOW_SIZE)
                    ? {{(32 - kcmpd_pkg::K_W){1'b0}}, r_window_size} : '0;
    assign k_eff  = (r_window_size < kcmpd_pkg::K_MIN) ? kcmpd_pkg::K_MIN : r_window_size;

    kcmpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .i_stat      (stat),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    kcmpd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_k           (k_eff),
        .i_coordinate  (i_coordinate),
        .i_out_ready   (i_ready),
        .o_stat        (stat),
        .o_out_valid   (o_valid),
        .o_position    (o_position),
        .o_last_result (o_last_result),
        .o_too_few     (o_too_few)
    );

`ifndef ASSERT_OFF
    // An error result always closes its set.
    a_toofew_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_few) |-> o_last_result)
        else $error("too_few result without last mark");

    // Closing a set stops intake until its results have been produced.
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_item) |=> !o_ready)
        else $error("input accepted right after the last item");

    // Results are only produced while intake is stopped, except the one waiting.
    a_no_new_result_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && $past(o_ready) && !$past(o_valid)) |-> !o_valid)
        else $error("result appeared during loading");
`endif

endmodule

FILE: sv/kcmpd_ctrl.sv
module kcmpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_item,
    input  kcmpd_pkg::t_stat  i_stat,
    output logic              o_ready,
    output kcmpd_pkg::t_cmd   o_cmd
);

    kcmpd_pkg::t_state r_state, n_state;
    kcmpd_pkg::t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcmpd_pkg::ST_IDLE;
            r_phase <= kcmpd_pkg::PH_READ;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            kcmpd_pkg::ST_IDLE: begin
                n_phase = kcmpd_pkg::PH_READ;
                if (i_valid && i_last_item) begin
                    n_state = i_stat.enough ? kcmpd_pkg::ST_SCAN : kcmpd_pkg::ST_TOOFEW;
                end
            end
            kcmpd_pkg::ST_SCAN: begin
                unique case (r_phase)
                    kcmpd_pkg::PH_READ: n_phase = kcmpd_pkg::PH_MUL;
                    kcmpd_pkg::PH_MUL:  n_phase = kcmpd_pkg::PH_SUB;
                    kcmpd_pkg::PH_SUB:  n_phase = kcmpd_pkg::PH_ADD;
                    kcmpd_pkg::PH_ADD:  n_phase = kcmpd_pkg::PH_ACC;
                    kcmpd_pkg::PH_ACC:  n_phase = kcmpd_pkg::PH_CMP;
                    kcmpd_pkg::PH_CMP: begin
                        n_phase = kcmpd_pkg::PH_READ;
                        if (i_stat.elem_last) begin
                            n_state = kcmpd_pkg::ST_SEEK;
                        end
                    end
                    default: n_phase = kcmpd_pkg::PH_READ;
                endcase
            end
            kcmpd_pkg::ST_SEEK: begin
                if (i_stat.at_start) begin
                    n_state = kcmpd_pkg::ST_EMIT;
                end
            end
            kcmpd_pkg::ST_EMIT: begin
                if (i_stat.slot_free && i_stat.sel_last) begin
                    n_state = kcmpd_pkg::ST_IDLE;
                end
            end
            kcmpd_pkg::ST_TOOFEW: begin
                if (i_stat.slot_free) begin
                    n_state = kcmpd_pkg::ST_IDLE;
                end
            end
            default: n_state = kcmpd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.phase = r_phase;
        unique case (r_state)
            kcmpd_pkg::ST_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.insert    = i_valid;
                o_cmd.scan_init = i_valid && i_last_item;
            end
            kcmpd_pkg::ST_SCAN: begin
                o_cmd.phase_en = 1'b1;
            end
            kcmpd_pkg::ST_SEEK: begin
                o_cmd.seek_rot  = !i_stat.at_start;
                o_cmd.seek_done = i_stat.at_start;
            end
            kcmpd_pkg::ST_EMIT: begin
                o_cmd.emit_load = i_stat.slot_free;
                o_cmd.clear     = i_stat.slot_free && i_stat.sel_last;
            end
            kcmpd_pkg::ST_TOOFEW: begin
                o_cmd.toofew_load = i_stat.slot_free;
                o_cmd.clear       = i_stat.slot_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/kcmpd_dp.sv
module kcmpd_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kcmpd_pkg::t_cmd                       i_cmd,
    input  logic [kcmpd_pkg::K_W-1:0]             i_k,
    input  logic signed [kcmpd_pkg::VAL_W-1:0]    i_coordinate,
    input  logic                                  i_out_ready,
    output kcmpd_pkg::t_stat                      o_stat,
    output logic                                  o_out_valid,
    output logic [kcmpd_pkg::POS_W-1:0]           o_position,
    output logic                                  o_last_result,
    output logic                                  o_too_few
);

    localparam int N = kcmpd_pkg::MAX_POINTS;

    // Sorted insertion chain, one cell per point.
    logic signed [kcmpd_pkg::VAL_W-1:0] r_val [N];
    logic [kcmpd_pkg::IDX_W-1:0]        r_pos [N];
    logic signed [kcmpd_pkg::VAL_W-1:0] ins_val [N];
    logic [kcmpd_pkg::IDX_W-1:0]        ins_pos [N];
    logic [N-1:0]                       le;
    logic [kcmpd_pkg::CNT_W-1:0]        r_count;
    logic                               full;
    logic                               rotate;

    // Scan datapath.
    logic signed [kcmpd_pkg::VAL_W-1:0] r_mem [N];
    logic [kcmpd_pkg::IDX_W-1:0]        r_e, r_t, r_j, r_bs;
    logic [kcmpd_pkg::IDX_W-1:0]        m, c;
    logic signed [kcmpd_pkg::VAL_W-1:0] r_xe, r_lead, r_prev;
    logic signed [kcmpd_pkg::RUN_W-1:0] r_p1, r_p2, r_run;
    logic signed [kcmpd_pkg::SUM_W-1:0] r_t1, r_t2, r_d, r_w, r_best;
    logic signed [kcmpd_pkg::SUM_W-1:0] run_ext;
    logic                               r_ov, r_olast, r_otf;
    logic [kcmpd_pkg::POS_W-1:0]        r_opos;

    assign full    = (r_count == kcmpd_pkg::CNT_W'(N));
    assign m       = kcmpd_pkg::IDX_W'(i_k - kcmpd_pkg::K_W'(1));
    assign c       = (r_e < m) ? r_e : m;
    assign run_ext = kcmpd_pkg::SUM_W'(r_run);
    assign rotate  = (i_cmd.phase_en && i_cmd.phase == kcmpd_pkg::PH_READ)
                     || i_cmd.seek_rot || i_cmd.emit_load;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            le[i] = (kcmpd_pkg::CNT_W'(i) < r_count) && (r_val[i] <= i_coordinate);
        end
        for (int i = 0; i < N; i++) begin
            if (le[i]) begin
                ins_val[i] = r_val[i];
                ins_pos[i] = r_pos[i];
            end else if (i == 0) begin
                ins_val[i] = i_coordinate;
                ins_pos[i] = r_count[kcmpd_pkg::IDX_W-1:0];
            end else if (le[i-1]) begin
                ins_val[i] = i_coordinate;
                ins_pos[i] = r_count[kcmpd_pkg::IDX_W-1:0];
            end else begin
                ins_val[i] = r_val[i-1];
                ins_pos[i] = r_pos[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !full) begin
            r_val <= ins_val;
            r_pos <= ins_pos;
        end else if (rotate) begin
            for (int i = 0; i < N; i++) begin
                r_val[i] <= (i == N - 1) ? r_val[0] : r_val[i+1];
                r_pos[i] <= (i == N - 1) ? r_pos[0] : r_pos[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.insert && !full) begin
            r_count <= r_count + kcmpd_pkg::CNT_W'(1);
        end
    end

    // Delay memory for the values leaving the window.
    always_ff @(posedge i_clk) begin
        if (i_cmd.phase_en && i_cmd.phase == kcmpd_pkg::PH_READ) begin
            r_mem[r_e] <= r_val[0];
            r_lead     <= r_mem[r_e - m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e    <= '0;
            r_t    <= '0;
            r_j    <= '0;
            r_bs   <= '0;
            r_w    <= '0;
            r_best <= '0;
            r_run  <= '0;
        end else begin
            if (i_cmd.scan_init) begin
                r_e   <= '0;
                r_t   <= '0;
                r_w   <= '0;
                r_run <= '0;
            end else if (rotate) begin
                r_t <= r_t + kcmpd_pkg::IDX_W'(1);
            end
            if (i_cmd.seek_done) begin
                r_j <= '0;
            end else if (i_cmd.emit_load) begin
                r_j <= r_j + kcmpd_pkg::IDX_W'(1);
            end
            if (i_cmd.phase_en) begin
                unique case (i_cmd.phase)
                    kcmpd_pkg::PH_READ: r_xe <= r_val[0];
                    kcmpd_pkg::PH_MUL: begin
                        r_p1 <= $signed({1'b0, c}) * kcmpd_pkg::RUN_W'(r_xe);
                        r_p2 <= $signed({1'b0, m}) * kcmpd_pkg::RUN_W'(r_prev);
                    end
                    kcmpd_pkg::PH_SUB: begin
                        r_t1 <= kcmpd_pkg::SUM_W'(r_p1) - run_ext;
                        r_t2 <= (r_e > m) ? kcmpd_pkg::SUM_W'(r_p2) - run_ext : '0;
                        r_run <= r_run + kcmpd_pkg::RUN_W'(r_xe)
                                 - ((r_e >= m) ? kcmpd_pkg::RUN_W'(r_lead) : '0);
                        r_prev <= r_lead;
                    end
                    kcmpd_pkg::PH_ADD: r_d <= r_t1 + r_t2;
                    kcmpd_pkg::PH_ACC: r_w <= r_w + r_d;
                    kcmpd_pkg::PH_CMP: begin
                        if (r_e == m) begin
                            r_best <= r_w;
                            r_bs   <= '0;
                        end else if (r_e > m && r_w < r_best) begin
                            r_best <= r_w;
                            r_bs   <= r_e - m;
                        end
                        r_e <= r_e + kcmpd_pkg::IDX_W'(1);
                    end
                    default: r_d <= r_d;
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.toofew_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_opos  <= kcmpd_pkg::POS_W'(r_pos[0]);
            r_olast <= (r_j == m);
            r_otf   <= 1'b0;
        end else if (i_cmd.toofew_load) begin
            r_opos  <= '0;
            r_olast <= 1'b1;
            r_otf   <= 1'b1;
        end
    end

    always_comb begin
        o_stat.enough    = ((full ? r_count : r_count + kcmpd_pkg::CNT_W'(1))
                            >= kcmpd_pkg::CNT_W'(i_k))
                           && (i_k <= kcmpd_pkg::K_W'(N));
        o_stat.elem_last = (kcmpd_pkg::CNT_W'(r_e) == r_count - kcmpd_pkg::CNT_W'(1));
        o_stat.at_start  = (r_t == r_bs);
        o_stat.sel_last  = (r_j == m);
        o_stat.slot_free = !r_ov || i_out_ready;
    end

    assign o_out_valid   = r_ov;
    assign o_position    = r_opos;
    assign o_last_result = r_olast;
    assign o_too_few     = r_otf;

endmodule

FILE: tb/sv/kcmpd_checker.sv
`timescale 1ns / 1ps

module kcmpd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kcmpd_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    input  logic                               pready,
    input  logic                               i_valid,
    input  logic                               o_ready,
    input  logic signed [kcmpd_pkg::VAL_W-1:0] i_coordinate,
    input  logic                               i_last_item,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic [kcmpd_pkg::POS_W-1:0]        o_position,
    input  logic                               o_last_result,
    input  logic                               o_too_few,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 points_in,
    output int                                 picks_out,
    output int                                 sets_closed,
    output int                                 short_sets
);

    typedef struct {
        logic [kcmpd_pkg::POS_W-1:0] position;
        logic                        last_result;
        logic                        too_few;
    } t_pick;

    // Predictor state: the set kept in ascending order, ties in arrival order.
    logic signed [kcmpd_pkg::VAL_W-1:0] set_val [kcmpd_pkg::MAX_POINTS];
    int                                 set_pos [kcmpd_pkg::MAX_POINTS];
    int                                 set_count;
    logic [kcmpd_pkg::K_W-1:0]          k_reg;
    t_pick                              picks_q[$];

    // Sum of pairwise distances of a sorted window equals
    // sum over j of (2j - (k-1)) * v[start+j].
    function automatic int best_window_start(int n, int k);
        longint best;
        longint cur;
        int     best_at;
        best = 0;
        best_at = 0;
        for (int s = 0; s + k <= n; s++) begin
            cur = 0;
            for (int j = 0; j < k; j++)
                cur += longint'(2 * j - (k - 1)) * longint'(set_val[s + j]);
            if (s == 0 || cur < best) begin
                best = cur;
                best_at = s;
            end
        end
        return best_at;
    endfunction

    task automatic take_point(logic signed [kcmpd_pkg::VAL_W-1:0] v, logic is_last);
        int    p;
        int    k;
        int    start;
        t_pick pk;
        if (set_count < kcmpd_pkg::MAX_POINTS) begin
            p = 0;
            while (p < set_count && set_val[p] <= v)
                p++;
            for (int j = set_count; j > p; j--) begin
                set_val[j] = set_val[j - 1];
                set_pos[j] = set_pos[j - 1];
            end
            set_val[p] = v;
            set_pos[p] = set_count;
            set_count++;
        end
        if (!is_last)
            return;
        k = (k_reg < kcmpd_pkg::K_MIN) ? int'(kcmpd_pkg::K_MIN) : int'(k_reg);
        if (set_count < k) begin
            pk.position = '0;
            pk.last_result = 1'b1;
            pk.too_few = 1'b1;
            picks_q.push_back(pk);
            short_sets++;
        end else begin
            start = best_window_start(set_count, k);
            for (int i = 0; i < k; i++) begin
                pk.position = kcmpd_pkg::POS_W'(set_pos[start + i]);
                pk.last_result = (i == k - 1);
                pk.too_few = 1'b0;
                picks_q.push_back(pk);
            end
        end
        sets_closed++;
        set_count = 0;
    endtask

    always @(posedge i_clk) begin
        t_pick e;
        if (!i_rst_n) begin
            set_count = 0;
            k_reg = kcmpd_pkg::K_RESET;
            picks_q.delete();
            points_in <= 0;
            picks_out <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == kcmpd_pkg::REG_WINDOW_SIZE)
                k_reg = pwdata[kcmpd_pkg::K_W-1:0];
            if (i_valid && o_ready) begin
                take_point(i_coordinate, i_last_item);
                points_in <= points_in + 1;
            end
            if (o_valid && i_ready) begin
                picks_out <= picks_out + 1;
                if (picks_q.size() == 0) begin
                    $display("%0t: unexpected result beat position=%0d last=%0b too_few=%0b",
                             $time, o_position, o_last_result, o_too_few);
                    fail_count++;
                end else begin
                    e = picks_q.pop_front();
                    if (e.position !== o_position || e.last_result !== o_last_result
                            || e.too_few !== o_too_few) begin
                        $display("%0t: mismatch expected pos=%0d last=%0b too_few=%0b,",
                                 $time, e.position, e.last_result, e.too_few);
                        $display("    got pos=%0d last=%0b too_few=%0b",
                                 o_position, o_last_result, o_too_few);
                        fail_count++;
                    end
                end
            end
        end
        pending <= picks_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        sets_closed = 0;
        short_sets = 0;
        points_in = 0;
        picks_out = 0;
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the testbench: it makes clock, reset and stimulus, and gives the
// verdict. All prediction and comparison lives in the checker beside the block.
module tb;

    localparam int IDLE_LIMIT = 5000;  // cycles without any beat before giving up
    localparam int SETTLE     = 600;   // covers a full 64-point scan and seek

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [kcmpd_pkg::ADDR_W-1:0]       paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               i_valid;
    logic                               o_ready;
    logic signed [kcmpd_pkg::VAL_W-1:0] i_coordinate;
    logic                               i_last_item;
    logic                               o_valid;
    logic                               i_ready;
    logic [kcmpd_pkg::POS_W-1:0]        o_position;
    logic                               o_last_result;
    logic                               o_too_few;

    int fail_count;
    int pending;
    int points_in;
    int picks_out;
    int sets_closed;
    int short_sets;

    // When calm is set, neither side inserts gaps, so the block runs flat out.
    logic calm;
    int   points_sent;
    int   idle_cycles;
    int   last_in;
    int   last_out;
    int   stall_left;

    k_cluster_min_pairwise_distance uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_coordinate(i_coordinate), .i_last_item(i_last_item),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_position(o_position), .o_last_result(o_last_result), .o_too_few(o_too_few)
    );

    kcmpd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_coordinate(i_coordinate), .i_last_item(i_last_item),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_position(o_position), .o_last_result(o_last_result), .o_too_few(o_too_few),
        .fail_count(fail_count), .pending(pending),
        .points_in(points_in), .picks_out(picks_out),
        .sets_closed(sets_closed), .short_sets(short_sets)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls at random. Everything here changes on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if (points_in != last_in || picks_out != last_out)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        last_in <= points_in;
        last_out <= picks_out;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog fired at %0t, %0d result beats still expected",
                     $time, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // A coordinate drawn from one of three flavors: anything at all, a narrow
    // range that makes ties common, or one of the extremes, zero or minus one.
    function automatic logic [kcmpd_pkg::VAL_W-1:0] pick_coordinate();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 9)
            return kcmpd_pkg::VAL_W'($urandom_range(0, 8)) - kcmpd_pkg::VAL_W'(4);
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // One beat on the input channel, after a random gap. The beat is known
    // to be taken when the checker's count of input beats moves.
    task automatic send_point(logic [kcmpd_pkg::VAL_W-1:0] c, logic is_last);
        int gap;
        int seen;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_coordinate <= c;
        i_last_item <= is_last;
        seen = points_in;
        do @(negedge i_clk); while (points_in == seen);
        points_sent++;
    endtask

    task automatic send_random_set(int n);
        for (int i = 0; i < n; i++)
            send_point(pick_coordinate(), i == n - 1);
    endtask

    // The window size is only changed while the block is idle: every expected
    // result has arrived, and a full scan's worth of cycles has passed since.
    task automatic set_window_size(int k);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= kcmpd_pkg::REG_WINDOW_SIZE;
        pwdata <= 32'(k);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int k;
        int n;
        int r;
        calm = 1'b0;
        points_sent = 0;
        idle_cycles = 0;
        last_in = 0;
        last_out = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_coordinate = '0;
        i_last_item = 1'b0;
        i_ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, at the reset window size of two first.
        // A lone point is too few for any window.
        send_point(32'd17, 1'b1);
        // The two extremes of the coordinate.
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b1);
        // Equal values must come out in arrival order.
        send_point(32'd5, 1'b0);
        send_point(32'd5, 1'b0);
        send_point(32'd5, 1'b1);

        set_window_size(3);
        calm = 1'b1;
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(32'd0, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'd1, 1'b0);
        send_point(32'hFFFF_FFFE, 1'b1);
        calm = 1'b0;
        // Two points against a window of three.
        send_point(32'd9, 1'b0);
        send_point(32'd9, 1'b1);

        // Window sizes below two behave as two.
        set_window_size(0);
        send_point(32'd100, 1'b0);
        send_point(32'd1, 1'b0);
        send_point(32'd2, 1'b1);
        set_window_size(1);
        send_point(32'd3, 1'b0);
        send_point(32'hFFFF_FFFD, 1'b1);

        // Largest window: exactly 64 points, then a set that overflows the store
        // and is closed by a mark on a dropped point.
        set_window_size(kcmpd_pkg::MAX_POINTS);
        send_random_set(kcmpd_pkg::MAX_POINTS);
        send_random_set(kcmpd_pkg::MAX_POINTS + 6);

        // Random part. Most sets are a little larger than the window, some are
        // short, and a few fill the store. The window size changes now and then.
        while (points_sent < 200) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                k = $urandom_range(2, 8);
            else if (r < 85)
                k = $urandom_range(9, 64);
            else if (r < 95)
                k = $urandom_range(0, 1);
            else
                k = $urandom_range(65, 127);
            set_window_size(k);
            calm = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < 4 && points_sent < 200; s++) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    n = (k < 2 ? 2 : k) + $urandom_range(0, 10);
                else if (r < 90)
                    n = $urandom_range(1, (k < 2 ? 2 : k));
                else
                    n = $urandom_range(60, 68);
                if (n > 70)
                    n = 70;
                send_random_set(n);
                // Once in a while hold off until every result is out.
                if ($urandom_range(0, 4) == 0) begin
                    i_valid <= 1'b0;
                    while (pending != 0)
                        @(negedge i_clk);
                end
            end
        end

        i_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Covered %0d points in %0d sets (%0d too short for their window),",
                 points_sent, sets_closed, short_sets);
        $display("with %0d result beats checked over window sizes from 0 to 127.", picks_out);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/kcmpd_pkg.sv
sv/kcmpd_ctrl.sv
sv/kcmpd_dp.sv
sv/k_cluster_min_pairwise_distance.sv
tb/sv/kcmpd_checker.sv
tb/sv/tb.sv
